>>> hw/rtl/dmc_pkg.sv
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types, constants and helpers for the direct-mapped cache tag check.
// ----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

  // default geometry
  localparam int MAX_INDEX_BITS_DEF   = 10;
  localparam int LINE_OFFSET_BITS_DEF = 5;
  localparam int ADDR_BITS_DEF        = 32;

  // fixed field widths
  localparam int CNT_W = 32;
  localparam int CFG_W = 4;

  // index width after reset
  localparam logic [CFG_W-1:0] INDEX_BITS_RST = 4'd8;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  // counter increment that sticks at all ones
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    r = (v == {CNT_W{1'b1}}) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dmc_ram.sv
// ----------------------------------------------------------------------------
// dmc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/dmc_addr_split.sv
// ----------------------------------------------------------------------------
// dmc_addr_split
// Cuts a byte address into line index and tag for the configured index width.
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_addr_split #(
  parameter int ADDR_BITS        = dmc_pkg::ADDR_BITS_DEF,
  parameter int LINE_OFFSET_BITS = dmc_pkg::LINE_OFFSET_BITS_DEF,
  parameter int MAX_INDEX_BITS   = dmc_pkg::MAX_INDEX_BITS_DEF
) (
  input  wire logic [ADDR_BITS-1:0]                    address,
  input  wire logic [dmc_pkg::CFG_W-1:0]               index_bits,
  output logic      [MAX_INDEX_BITS-1:0]               line_index,
  output logic      [ADDR_BITS-LINE_OFFSET_BITS-2:0]   line_tag
);

  import dmc_pkg::*;

  localparam int IB_W  = $clog2(MAX_INDEX_BITS + 1);
  localparam int UP_W  = ADDR_BITS - LINE_OFFSET_BITS;
  localparam int TAG_W = UP_W - 1;

  logic [IB_W-1:0]           used_bits;
  logic [MAX_INDEX_BITS-1:0] index_mask;
  logic [UP_W-1:0]           upper;
  logic [UP_W-1:0]           upper_shifted;

  // clamp the index width to the supported range
  always_comb begin
    if (index_bits == '0) begin
      used_bits = IB_W'(1);
    end else if (int'(index_bits) > MAX_INDEX_BITS) begin
      used_bits = IB_W'(MAX_INDEX_BITS);
    end else begin
      used_bits = IB_W'(index_bits);
    end
  end

  // mask of the index bits in use
  always_comb begin
    for (int i = 0; i < MAX_INDEX_BITS; i++) begin
      index_mask[i] = (i < int'(used_bits));
    end
  end

  // index sits just above the line offset
  assign line_index = address[LINE_OFFSET_BITS +: MAX_INDEX_BITS] & index_mask;

  // tag is everything above the index
  assign upper         = address[ADDR_BITS-1:LINE_OFFSET_BITS];
  assign upper_shifted = upper >> used_bits;
  assign line_tag      = upper_shifted[TAG_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/direct_mapped_cache_tag_check_top.sv
// ----------------------------------------------------------------------------
// direct_mapped_cache_tag_check_top
// The lookup RAM is read at the accept edge; in the LOOKUP state the tag is
// compared, the result is registered and shown on out_valid for one cycle.
// A new transaction is taken only once the read-compare-write pass over the
// single line RAM (valid bit and tag in one entry) is done; busy is high meanwhile.
// After reset a clearing pass writes every line invalid, one line a cycle,
// with busy high; config writes are taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module direct_mapped_cache_tag_check_top #(
  parameter int MAX_INDEX_BITS   = dmc_pkg::MAX_INDEX_BITS_DEF,
  parameter int LINE_OFFSET_BITS = dmc_pkg::LINE_OFFSET_BITS_DEF,
  parameter int ADDR_BITS        = dmc_pkg::ADDR_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // configuration
  input  wire logic                       cfg_we,
  input  wire logic [dmc_pkg::CFG_W-1:0]  cfg_wdata,
  // access transactions
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [ADDR_BITS-1:0]       in_address,
  // results
  output logic                            out_valid,
  output logic                            out_hit,
  output logic      [dmc_pkg::CNT_W-1:0]  out_hit_count,
  output logic      [dmc_pkg::CNT_W-1:0]  out_miss_count,
  output logic      [dmc_pkg::CNT_W-1:0]  out_total_count
);

  import dmc_pkg::*;

  localparam int IDX_W   = MAX_INDEX_BITS;
  localparam int DEPTH   = 1 << MAX_INDEX_BITS;
  localparam int TAG_W   = ADDR_BITS - LINE_OFFSET_BITS - 1;
  localparam int ENTRY_W = TAG_W + 1;

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic [CFG_W-1:0]   index_bits_r;
  logic [IDX_W-1:0]   index_r;
  logic [TAG_W-1:0]   tag_r;
  logic               out_valid_r;
  logic               out_hit_r;
  logic [CNT_W-1:0]   hit_cnt_r, miss_cnt_r, total_cnt_r;

  logic [IDX_W-1:0]   split_index;
  logic [TAG_W-1:0]   split_tag;
  logic               accept;
  logic               clearing;
  logic               lookup;
  logic               clr_done;
  logic               hit;
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  // address decode of the incoming transaction
  dmc_addr_split #(
    .ADDR_BITS        (ADDR_BITS),
    .LINE_OFFSET_BITS (LINE_OFFSET_BITS),
    .MAX_INDEX_BITS   (MAX_INDEX_BITS)
  ) u_split (
    .address    (in_address),
    .index_bits (index_bits_r),
    .line_index (split_index),
    .line_tag   (split_tag)
  );

  // line store: valid bit over tag
  dmc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (split_index),
    .rdata (ram_rdata)
  );

  assign accept   = start && !busy;
  assign clr_done = (clr_idx_r == {IDX_W{1'b1}});
  assign hit      = ram_rdata[ENTRY_W-1] && (ram_rdata[TAG_W-1:0] == tag_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_done) state_nxt = ST_IDLE;
      ST_IDLE:   if (start) state_nxt = ST_LOOKUP;
      ST_LOOKUP: state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // state decoded controls
  always_comb begin
    busy     = 1'b1;
    clearing = 1'b0;
    lookup   = 1'b0;
    case (state_r)
      ST_CLEAR:  clearing = 1'b1;
      ST_IDLE:   busy     = 1'b0;
      ST_LOOKUP: lookup   = 1'b1;
      default:   clearing = 1'b0;
    endcase
  end

  // clear sweep address
  assign clr_idx_nxt = clearing ? clr_idx_r + {{(IDX_W-1){1'b0}}, 1'b1} : clr_idx_r;

  // ram write: invalidate during the sweep, fill on a miss
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = index_r;
    ram_wdata = {1'b1, tag_r};
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = '0;
    end else if (lookup && !hit) begin
      ram_we = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_idx_r    <= '0;
      index_bits_r <= INDEX_BITS_RST;
      out_valid_r  <= 1'b0;
      hit_cnt_r    <= '0;
      miss_cnt_r   <= '0;
      total_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= lookup;
      if (cfg_we) begin
        index_bits_r <= cfg_wdata;
      end
      if (lookup) begin
        total_cnt_r <= sat_inc(total_cnt_r);
        if (hit) begin
          hit_cnt_r <= sat_inc(hit_cnt_r);
        end else begin
          miss_cnt_r <= sat_inc(miss_cnt_r);
        end
      end
    end
  end

  // transaction payload
  always_ff @(posedge clk) begin
    if (accept) begin
      index_r <= split_index;
      tag_r   <= split_tag;
    end
    if (lookup) begin
      out_hit_r <= hit;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_hit_count   = hit_cnt_r;
  assign out_miss_count  = miss_cnt_r;
  assign out_total_count = total_cnt_r;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the direct-mapped cache tag check. A short table of
// directed accesses and index-width writes runs first, then phases of random
// accesses biased towards reuse and line conflicts, each phase under its own
// index width. Every accepted access is run through a local cache model and
// the result strobes are compared field by field, in order.
// ----------------------------------------------------------------------------

module tb_top;
  import dmc_pkg::*;

  localparam int ADDR_W      = ADDR_BITS_DEF;
  localparam int OFFSET_BITS = LINE_OFFSET_BITS_DEF;
  localparam int MAX_IDX     = MAX_INDEX_BITS_DEF;
  localparam int LINES       = 1 << MAX_IDX;
  localparam int TAG_W       = ADDR_W - OFFSET_BITS - 1;
  localparam int STALL_LIMIT = 5000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 62;
  localparam int DIR_ROWS    = 25;
  localparam int RECENT_MAX  = 16;

  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] hit_count;
    logic [CNT_W-1:0] miss_count;
    logic [CNT_W-1:0] total_count;
  } access_result_t;

  typedef enum logic {
    ROW_ACCESS,
    ROW_CONFIG
  } row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [ADDR_W-1:0] value;
    logic             typed;
    access_result_t   res;
  } stim_row_t;

  // clock and dut ports
  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              cfg_we      = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata   = '0;
  logic              start       = 1'b0;
  logic [ADDR_W-1:0] in_address  = '0;
  logic              busy;
  logic              out_valid;
  logic              out_hit;
  logic [CNT_W-1:0]  out_hit_count;
  logic [CNT_W-1:0]  out_miss_count;
  logic [CNT_W-1:0]  out_total_count;

  // cache model state
  logic              model_valid [LINES];
  logic [TAG_W-1:0]  model_tag   [LINES];
  logic [CNT_W-1:0]  model_hits   = '0;
  logic [CNT_W-1:0]  model_misses = '0;
  logic [CNT_W-1:0]  model_total  = '0;
  logic [CFG_W-1:0]  model_index_bits = INDEX_BITS_RST;

  access_result_t    expected_lookups [$];
  logic [ADDR_W-1:0] recent_addrs [$];
  int                mismatch_count = 0;
  int                idle_cycles    = 0;

  // directed accesses; counts typed in where they follow at a glance
  stim_row_t dir_table [DIR_ROWS] = '{
    '{ROW_ACCESS, 32'h0000_0000, 1'b1, '{1'b0, 32'd0, 32'd1, 32'd1}},
    '{ROW_ACCESS, 32'h0000_0000, 1'b1, '{1'b1, 32'd1, 32'd1, 32'd2}},
    '{ROW_ACCESS, 32'h0000_001F, 1'b1, '{1'b1, 32'd2, 32'd1, 32'd3}},
    '{ROW_ACCESS, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'd2, 32'd2, 32'd4}},
    '{ROW_ACCESS, 32'hFFFF_FFE0, 1'b1, '{1'b1, 32'd3, 32'd2, 32'd5}},
    '{ROW_ACCESS, 32'h0000_2000, 1'b1, '{1'b0, 32'd3, 32'd3, 32'd6}},
    '{ROW_ACCESS, 32'h0000_0000, 1'b1, '{1'b0, 32'd3, 32'd4, 32'd7}},
    '{ROW_ACCESS, 32'h0000_0020, 1'b1, '{1'b0, 32'd3, 32'd5, 32'd8}},
    '{ROW_ACCESS, 32'h0000_003F, 1'b1, '{1'b1, 32'd4, 32'd5, 32'd9}},
    // zero width is taken as one, old lines kept
    '{ROW_CONFIG, 32'd0,         1'b0, '0},
    '{ROW_ACCESS, 32'h0000_0000, 1'b0, '0},
    '{ROW_ACCESS, 32'h0000_0040, 1'b0, '0},
    '{ROW_ACCESS, 32'hAAAA_AAAA, 1'b0, '0},
    '{ROW_ACCESS, 32'hAAAA_AAAA, 1'b0, '0},
    // over-wide setting is clipped to the largest width
    '{ROW_CONFIG, 32'd15,        1'b0, '0},
    '{ROW_ACCESS, 32'h5555_5555, 1'b0, '0},
    '{ROW_ACCESS, 32'h5555_5555, 1'b0, '0},
    '{ROW_ACCESS, 32'h0000_7FE0, 1'b0, '0},
    '{ROW_CONFIG, 32'd10,        1'b0, '0},
    '{ROW_ACCESS, 32'h0000_7FE0, 1'b0, '0},
    '{ROW_CONFIG, 32'd1,         1'b0, '0},
    '{ROW_ACCESS, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_CONFIG, 32'd8,         1'b0, '0},
    '{ROW_ACCESS, 32'h0000_2000, 1'b0, '0},
    '{ROW_ACCESS, 32'h0000_2000, 1'b0, '0}
  };

  direct_mapped_cache_tag_check_top u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .start           (start),
    .busy            (busy),
    .in_address      (in_address),
    .out_valid       (out_valid),
    .out_hit         (out_hit),
    .out_hit_count   (out_hit_count),
    .out_miss_count  (out_miss_count),
    .out_total_count (out_total_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // effective index width after clipping
  function automatic int unsigned used_index_bits();
    if (model_index_bits < 1) return 1;
    if (model_index_bits > MAX_IDX) return MAX_IDX;
    return model_index_bits;
  endfunction

  // look one access up in the model, fill on miss, bump the counters
  function automatic access_result_t lookup_access(input logic [ADDR_W-1:0] addr);
    int unsigned    ib;
    logic [MAX_IDX-1:0] line_no;
    logic [TAG_W-1:0]   tag_val;
    access_result_t r;
    ib      = used_index_bits();
    line_no = MAX_IDX'((addr >> OFFSET_BITS) & ((32'd1 << ib) - 32'd1));
    tag_val = TAG_W'(addr >> (OFFSET_BITS + ib));
    r.hit   = model_valid[line_no] && (model_tag[line_no] == tag_val);
    if (r.hit) begin
      if (model_hits != '1) model_hits = model_hits + 1'b1;
    end else begin
      if (model_misses != '1) model_misses = model_misses + 1'b1;
      model_valid[line_no] = 1'b1;
      model_tag[line_no]   = tag_val;
    end
    if (model_total != '1) model_total = model_total + 1'b1;
    r.hit_count   = model_hits;
    r.miss_count  = model_misses;
    r.total_count = model_total;
    return r;
  endfunction

  // random address: mostly reuse of recent lines, some conflicts, some noise
  function automatic logic [ADDR_W-1:0] next_address();
    logic [ADDR_W-1:0] a;
    int unsigned       pick;
    pick = $urandom_range(0, 9);
    if (recent_addrs.size() == 0 || pick >= 8) begin
      a = $urandom;
    end else if (pick == 7) begin
      a = $urandom_range(0, 32'h3FFF);
    end else begin
      a = recent_addrs[$urandom_range(0, recent_addrs.size() - 1)];
      a[OFFSET_BITS-1:0] = OFFSET_BITS'($urandom);
      // same line, other tag
      if (pick >= 5)
        a = a ^ (32'($urandom_range(1, 7)) << (OFFSET_BITS + used_index_bits()));
    end
    recent_addrs.push_back(a);
    if (recent_addrs.size() > RECENT_MAX) void'(recent_addrs.pop_front());
    return a;
  endfunction

  // offer one access and hold it until taken
  task automatic issue_access(input logic [ADDR_W-1:0] addr, input logic typed,
                              input access_result_t typed_res);
    access_result_t r;
    start      <= 1'b1;
    in_address <= addr;
    do @(posedge clk); while (busy !== 1'b0);
    r = lookup_access(addr);
    if (typed) r = typed_res;
    expected_lookups.push_back(r);
  endtask

  task automatic idle_gap(input int unsigned n);
    start      <= 1'b0;
    in_address <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  // index width is only changed once every result is back
  task automatic write_index_bits(input logic [CFG_W-1:0] v);
    start <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we           <= 1'b0;
    model_index_bits  = v;
  endtask

  task automatic report_field(input string name, input logic [CNT_W-1:0] want,
                              input logic [CNT_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  // stimulus
  initial begin : stimulus
    int unsigned idle_odds;
    for (int i = 0; i < LINES; i++) begin
      model_valid[i] = 1'b0;
      model_tag[i]   = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CONFIG)
        write_index_bits(dir_table[i].value[CFG_W-1:0]);
      else
        issue_access(dir_table[i].value, dir_table[i].typed, dir_table[i].res);
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0: write_index_bits(CFG_W'(1));
        1: write_index_bits(CFG_W'(10));
        2: write_index_bits(CFG_W'(0));
        3: write_index_bits(CFG_W'(15));
        4: write_index_bits(CFG_W'(8));
        5: write_index_bits(CFG_W'(3));
        default: write_index_bits(CFG_W'($urandom_range(0, 15)));
      endcase
      // no idling in the final phase
      idle_odds = (phase == RAND_PHASES - 1) ? 0 : $urandom_range(2, 8);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
          idle_gap($urandom_range(1, 9));
        issue_access(next_address(), 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0)
      $display("** direct_mapped_cache_tag_check_top: PASSED **");
    else
      $display("** direct_mapped_cache_tag_check_top: FAILED **");
    $finish;
  end

  // result checker
  always @(posedge clk) begin : result_check
    access_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_lookups.size() == 0) begin
        mismatch_count++;
        $display("%0t: result with no access outstanding, actual hit %0b", $time, out_hit);
      end else begin
        want = expected_lookups.pop_front();
        report_field("hit", CNT_W'(want.hit), CNT_W'(out_hit));
        report_field("hit_count", want.hit_count, out_hit_count);
        report_field("miss_count", want.miss_count, out_miss_count);
        report_field("total_count", want.total_count, out_total_count);
      end
    end
  end

  // watchdog on cycles with no transaction either side
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, nothing accepted for %0d cycles", $time, STALL_LIMIT);
      $display("** direct_mapped_cache_tag_check_top: FAILED **");
      $finish;
    end
  end

endmodule
